### design/pab_pkg.sv
// ----------------------------------------------------------------------------
// Pixel alpha blender package
// Shared types, register indexes, blend codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pab_pkg;

  // Frame size limits used as parameter defaults.
  localparam int unsigned MaxWidthDefault  = 2048;
  localparam int unsigned MaxHeightDefault = 2048;

  // Field widths.
  localparam int unsigned CoordW   = 16;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned SizeW    = 12;
  localparam int unsigned IndexW   = 22;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned NumChan  = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_BLEND_MODE = 3'd0,
    REG_BG_COLOR   = 3'd1,
    REG_AA_ENABLE  = 3'd2,
    REG_WIDTH      = 3'd3,
    REG_HEIGHT     = 3'd4
  } cfg_reg_e;

  // Blend modes; the fourth code has no meaning and keeps the old color when antialiasing is on.
  typedef enum logic [1:0] {
    BLEND_OVER  = 2'd0,
    BLEND_DELTA = 2'd1,
    BLEND_ADD   = 2'd2
  } blend_mode_e;

  // Register reset values.
  localparam blend_mode_e       ModeReset   = BLEND_OVER;
  localparam logic [ColorW-1:0] BgReset     = '0;
  localparam logic              AaReset     = 1'b1;
  localparam logic [SizeW-1:0]  WidthReset  = 12'd640;
  localparam logic [SizeW-1:0]  HeightReset = 12'd480;

  // Alpha complement constant.
  localparam logic [ChanW-1:0] AlphaMask = 8'hFF;

  typedef logic [ChanW-1:0] chan_t;

endpackage : pab_pkg

`default_nettype wire

### design/pixel_alpha_blender_unit.sv
// ----------------------------------------------------------------------------
// Pixel alpha blender unit
// Bounds-checks one pixel per clock; with antialiasing on, blends its RGB
// with the frame buffer value in the selected mode, saturating to 0..255.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   -------------------------------
//   request   start_i / busy_o             pixel_x/y, src_rgba, old_rgb
//   result    result_valid_o (strobe)      pixel_index, out_rgb, store_pixel
//   config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One request is taken every clock; busy_o stays low. The pipeline has three
// register stages (input, multiply, saturate), and a result strobes as its
// request leaves the saturate stage. A pixel outside the frame drops its
// valid bit at entry and produces no result. Reset clears the stage valid
// bits and loads the register defaults. The receiver cannot stall, so the
// pipeline never holds.
//
`default_nettype none

module pixel_alpha_blender_unit #(
  parameter int unsigned MAX_WIDTH  = pab_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = pab_pkg::MaxHeightDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request channel.
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [pab_pkg::CoordW-1:0]    pixel_x_i,
  input  wire logic [pab_pkg::CoordW-1:0]    pixel_y_i,
  input  wire logic [pab_pkg::ChanW-1:0]     src_red_i,
  input  wire logic [pab_pkg::ChanW-1:0]     src_green_i,
  input  wire logic [pab_pkg::ChanW-1:0]     src_blue_i,
  input  wire logic [pab_pkg::ChanW-1:0]     src_alpha_i,
  input  wire logic [pab_pkg::ChanW-1:0]     old_red_i,
  input  wire logic [pab_pkg::ChanW-1:0]     old_green_i,
  input  wire logic [pab_pkg::ChanW-1:0]     old_blue_i,
  // Result channel.
  output logic                               result_valid_o,
  output logic [pab_pkg::IndexW-1:0]         pixel_index_o,
  output logic [pab_pkg::ChanW-1:0]          out_red_o,
  output logic [pab_pkg::ChanW-1:0]          out_green_o,
  output logic [pab_pkg::ChanW-1:0]          out_blue_o,
  output logic                               store_pixel_o,
  // Configuration channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pab_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pab_pkg::CfgDataW-1:0]  cfg_data_i
);

  import pab_pkg::*;

  // Configuration registers.
  blend_mode_e        mode_q;
  logic [ColorW-1:0]  bg_q;
  logic               aa_q;
  logic [SizeW-1:0]   width_q;
  logic [SizeW-1:0]   height_q;

  // Effective frame size after clamping to the build limits.
  logic [SizeW-1:0]   width_eff;
  logic [SizeW-1:0]   height_eff;

  // Request handshake.
  logic               accept;
  logic               in_frame;

  // Stage 1: registered request.
  logic               s1_valid_q;
  logic [SizeW-1:0]   s1_x_q;
  logic [CoordW-1:0]  s1_y_q;
  chan_t              s1_src_q [NumChan];
  chan_t              s1_old_q [NumChan];
  chan_t              s1_alpha_q;
  chan_t              src_in   [NumChan];
  chan_t              old_in   [NumChan];

  // Stage 2: products.
  logic               s2_valid_q;
  logic [IndexW-1:0]  s2_row_q;
  logic [SizeW-1:0]   s2_x_q;
  chan_t              s2_src_q  [NumChan];
  chan_t              s2_old_q  [NumChan];
  logic signed [17:0] s2_pa_q   [NumChan];
  logic [15:0]        s2_pb_q   [NumChan];
  logic [27:0]        row_full;

  // Stage 3: result registers.
  logic               s3_valid_q;
  logic [IndexW-1:0]  s3_index_q;
  chan_t              s3_rgb_q  [NumChan];
  logic               s3_store_q;
  chan_t              blended   [NumChan];
  chan_t              rgb_d     [NumChan];
  logic               store_d;

  // The block never stalls.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeReset;
      bg_q     <= BgReset;
      aa_q     <= AaReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BLEND_MODE: mode_q   <= blend_mode_e'(cfg_data_i[1:0]);
        REG_BG_COLOR:   bg_q     <= cfg_data_i[ColorW-1:0];
        REG_AA_ENABLE:  aa_q     <= cfg_data_i[0];
        REG_WIDTH:      width_q  <= cfg_data_i[SizeW-1:0];
        REG_HEIGHT:     height_q <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the build limits.
  always_comb begin
    width_eff  = width_q;
    height_eff = height_q;
    if (32'(width_q) > MAX_WIDTH) begin
      width_eff = SizeW'(MAX_WIDTH);
    end
    if (32'(height_q) > MAX_HEIGHT) begin
      height_eff = SizeW'(MAX_HEIGHT);
    end
  end

  // Accept and bounds check at entry.
  assign accept   = start_i && !busy_o;
  assign in_frame = (pixel_x_i < CoordW'(width_eff)) && (pixel_y_i < CoordW'(height_eff));

  assign src_in[0] = src_red_i;
  assign src_in[1] = src_green_i;
  assign src_in[2] = src_blue_i;
  assign old_in[0] = old_red_i;
  assign old_in[1] = old_green_i;
  assign old_in[2] = old_blue_i;

  // Stage 1 valid and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && in_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q     <= pixel_x_i[SizeW-1:0];
    s1_y_q     <= pixel_y_i;
    s1_alpha_q <= src_alpha_i;
    s1_src_q   <= src_in;
    s1_old_q   <= old_in;
  end

  // Row offset product.
  assign row_full = s1_y_q * width_eff;

  // Stage 2: one signed and one unsigned product per channel.
  for (genvar c = 0; c < NumChan; c++) begin : g_mult
    logic signed [8:0]  operand;
    logic signed [17:0] prod_a;
    logic [15:0]        prod_b;

    // Source minus background in delta mode, plain source otherwise.
    always_comb begin
      if (mode_q == BLEND_DELTA) begin
        operand = $signed({1'b0, s1_src_q[c]}) - $signed({1'b0, bg_q[c*ChanW +: ChanW]});
      end else begin
        operand = $signed({1'b0, s1_src_q[c]});
      end
      prod_a = operand * $signed({1'b0, s1_alpha_q});
      prod_b = s1_old_q[c] * (s1_alpha_q ^ AlphaMask);
    end

    always_ff @(posedge clk_i) begin
      s2_pa_q[c] <= prod_a;
      s2_pb_q[c] <= prod_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_row_q <= row_full[IndexW-1:0];
    s2_x_q   <= s1_x_q;
    s2_src_q <= s1_src_q;
    s2_old_q <= s1_old_q;
  end

  // Stage 3: scale, add and saturate each channel.
  for (genvar c = 0; c < NumChan; c++) begin : g_sum
    logic signed [9:0]  term_a;
    logic [8:0]         term_b;
    logic signed [10:0] total;

    always_comb begin
      // Arithmetic shift gives floor division for the signed delta product.
      term_a = s2_pa_q[c][17:8];
      if (mode_q == BLEND_OVER) begin
        term_b = {1'b0, s2_pb_q[c][15:8]};
      end else begin
        term_b = {1'b0, s2_old_q[c]};
      end
      total = 11'(term_a) + $signed({2'b00, term_b});
      if (total < 0) begin
        blended[c] = '0;
      end else if (total > 11'sd255) begin
        blended[c] = 8'hFF;
      end else begin
        blended[c] = total[ChanW-1:0];
      end
    end
  end

  // Select the output color and store flag.
  always_comb begin
    if (!aa_q) begin
      rgb_d   = s2_src_q;
      store_d = 1'b0;
    end else begin
      case (mode_q)
        BLEND_OVER, BLEND_DELTA, BLEND_ADD: begin
          rgb_d   = blended;
          store_d = 1'b1;
        end
        default: begin
          rgb_d   = s2_old_q;
          store_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_index_q <= s2_row_q + IndexW'(s2_x_q);
    s3_rgb_q   <= rgb_d;
    s3_store_q <= store_d;
  end

  // Result ports.
  assign result_valid_o = s3_valid_q;
  assign pixel_index_o  = s3_index_q;
  assign out_red_o      = s3_rgb_q[0];
  assign out_green_o    = s3_rgb_q[1];
  assign out_blue_o     = s3_rgb_q[2];
  assign store_pixel_o  = s3_store_q;

endmodule : pixel_alpha_blender_unit

`default_nettype wire

### design/pab_checker.sv
// ----------------------------------------------------------------------------
// Pixel alpha blender checker
// Port-level checks on result timing and bounds, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pab_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic [pab_pkg::CoordW-1:0]    pixel_x_i,
  input wire logic [pab_pkg::CoordW-1:0]    pixel_y_i,
  input wire logic                          result_valid_o,
  input wire logic [pab_pkg::IndexW-1:0]    pixel_index_o,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o
);

  import pab_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // A result always follows an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 3))
    else $error("result without a request three cycles earlier");

  // The origin pixel always maps to index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(pixel_x_i == '0 && pixel_y_i == '0, 3))
      |-> (pixel_index_o == '0))
    else $error("origin pixel gave a nonzero index");

  // Coordinates beyond any programmable frame size give no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(accept && (pixel_x_i[CoordW-1:SizeW] != '0 || pixel_y_i[CoordW-1:SizeW] != '0), 3)
      |-> !result_valid_o)
    else $error("out of frame pixel produced a result");

  // A result seen while configuration is being written must still follow an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !result_valid_o || $past(accept, 3))
    else $error("result seen during configuration without a request");

endmodule : pab_checker

bind pixel_alpha_blender_unit pab_checker u_pab_checker (.*);

`default_nettype wire

### test/pixel_alpha_blender_unit_tb.sv
// ----------------------------------------------------------------------------
// Pixel alpha blender unit testbench
// Drives pixels through the request port and predicts each blended result
// from a local copy of the registers. It runs directed cases for the frame
// bounds, every blend mode and the pass-through path. It then runs random
// pixels under several register settings and sender idle rates.
// ----------------------------------------------------------------------------

module pixel_alpha_blender_unit_tb;
  import pab_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 5;
  localparam int SettleCycles  = 8;
  localparam int DrainLimit    = 1000;
  localparam int TimeoutCycles = 200000;
  localparam int MaxReport     = 10;

  // Blend code with no defined meaning; the block returns the old color when antialiasing is on.
  localparam logic [1:0] BlendReserved = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    chan_t             src_red;
    chan_t             src_green;
    chan_t             src_blue;
    chan_t             src_alpha;
    chan_t             old_red;
    chan_t             old_green;
    chan_t             old_blue;
  } pixel_req_t;

  typedef struct packed {
    logic [IndexW-1:0] index;
    chan_t             red;
    chan_t             green;
    chan_t             blue;
    logic              store;
  } pixel_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [CoordW-1:0]     pixel_x_i;
  logic [CoordW-1:0]     pixel_y_i;
  chan_t                 src_red_i;
  chan_t                 src_green_i;
  chan_t                 src_blue_i;
  chan_t                 src_alpha_i;
  chan_t                 old_red_i;
  chan_t                 old_green_i;
  chan_t                 old_blue_i;
  logic                  result_valid_o;
  logic [IndexW-1:0]     pixel_index_o;
  chan_t                 out_red_o;
  chan_t                 out_green_o;
  chan_t                 out_blue_o;
  logic                  store_pixel_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  // Local copy of the configuration registers.
  logic [1:0]            cur_mode   = ModeReset;
  logic [ColorW-1:0]     cur_bg     = BgReset;
  logic                  cur_aa     = AaReset;
  logic [SizeW-1:0]      cur_width  = WidthReset;
  logic [SizeW-1:0]      cur_height = HeightReset;

  pixel_res_t            pending_pixels [$];
  int                    expected_count = 0;
  int                    mismatch_count = 0;
  int                    idle_pct       = 0;

  pixel_alpha_blender_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .src_red_i      (src_red_i),
    .src_green_i    (src_green_i),
    .src_blue_i     (src_blue_i),
    .src_alpha_i    (src_alpha_i),
    .old_red_i      (old_red_i),
    .old_green_i    (old_green_i),
    .old_blue_i     (old_blue_i),
    .result_valid_o (result_valid_o),
    .pixel_index_o  (pixel_index_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .store_pixel_o  (store_pixel_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Frame size as the block sees it, clamped to the build limits.
  function automatic int unsigned eff_width();
    return (cur_width > MaxWidthDefault) ? MaxWidthDefault : cur_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cur_height > MaxHeightDefault) ? MaxHeightDefault : cur_height;
  endfunction

  // One blended channel in the current mode, saturated to 0..255.
  function automatic chan_t blend_channel(chan_t c, chan_t a, chan_t old, chan_t bg);
    int v;
    case (cur_mode)
      BLEND_OVER: begin
        v = ((int'(c) * int'(a)) >>> 8) + ((int'(old) * int'(a ^ AlphaMask)) >>> 8);
      end
      BLEND_DELTA: begin
        // Arithmetic shift rounds a negative delta toward minus infinity.
        v = (((int'(c) - int'(bg)) * int'(a)) >>> 8) + int'(old);
      end
      default: begin
        // Additive blend.
        v = ((int'(c) * int'(a)) >>> 8) + int'(old);
      end
    endcase
    if (v < 0) return '0;
    if (v > 255) return '1;
    return chan_t'(v);
  endfunction

  // Predicts the result of one pixel; returns 0 when it lies outside the frame.
  function automatic bit blend_pixel(input pixel_req_t p, output pixel_res_t r);
    int unsigned w;
    int unsigned h;
    w = eff_width();
    h = eff_height();
    r = '0;
    if (p.x >= w || p.y >= h) return 1'b0;
    r.index = IndexW'(p.x + p.y * w);
    if (!cur_aa) begin
      r.red   = p.src_red;
      r.green = p.src_green;
      r.blue  = p.src_blue;
      r.store = 1'b0;
    end else if (cur_mode == BlendReserved) begin
      r.red   = p.old_red;
      r.green = p.old_green;
      r.blue  = p.old_blue;
      r.store = 1'b0;
    end else begin
      r.red   = blend_channel(p.src_red, p.src_alpha, p.old_red, cur_bg[7:0]);
      r.green = blend_channel(p.src_green, p.src_alpha, p.old_green, cur_bg[15:8]);
      r.blue  = blend_channel(p.src_blue, p.src_alpha, p.old_blue, cur_bg[23:16]);
      r.store = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic pixel_req_t make_pixel(int x, int y, int r, int g, int b, int a,
                                            int o_r, int o_g, int o_b);
    pixel_req_t p;
    p = '{CoordW'(x), CoordW'(y), chan_t'(r), chan_t'(g), chan_t'(b), chan_t'(a),
          chan_t'(o_r), chan_t'(o_g), chan_t'(o_b)};
    return p;
  endfunction

  // Random pixel, mostly inside the current frame, with extra weight on the
  // alpha extremes.
  function automatic pixel_req_t random_pixel();
    pixel_req_t  p;
    int unsigned w;
    int unsigned h;
    w = eff_width();
    h = eff_height();
    p = pixel_req_t'({$urandom(), $urandom(), $urandom()});
    if (w != 0 && $urandom_range(99) < 92) p.x = CoordW'($urandom_range(w - 1, 0));
    if (h != 0 && $urandom_range(99) < 92) p.y = CoordW'($urandom_range(h - 1, 0));
    case ($urandom_range(9))
      0: p.src_alpha = '0;
      1: p.src_alpha = '1;
      default: ;
    endcase
    return p;
  endfunction

  // Sends one request, with random idle cycles before it. Each cycle is idle
  // with the chance idle_pct, so that share of all cycles is idle. The start
  // line stays high afterwards so back-to-back requests need no extra step.
  task automatic send_pixel(input pixel_req_t p);
    pixel_res_t r;
    if (idle_pct != 0) begin
      while ($urandom_range(99) < idle_pct) begin
        start_i <= 1'b0;
        {pixel_x_i, pixel_y_i, src_red_i, src_green_i, src_blue_i, src_alpha_i,
         old_red_i, old_green_i, old_blue_i} <=
          pixel_req_t'({$urandom(), $urandom(), $urandom()});
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    {pixel_x_i, pixel_y_i, src_red_i, src_green_i, src_blue_i, src_alpha_i,
     old_red_i, old_green_i, old_blue_i} <= p;
    do @(posedge clk_i); while (busy_o);
    if (blend_pixel(p, r)) begin
      pending_pixels.push_back(r);
      expected_count++;
    end
  endtask

  // Stops sending, waits for every pending result, then lets the pipeline
  // flush any dropped pixels still in flight.
  task automatic wait_idle();
    int n;
    start_i <= 1'b0;
    n = 0;
    while (pending_pixels.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all five registers once the block is idle.
  task automatic configure(logic [1:0] mode, logic [ColorW-1:0] bg, logic aa,
                           logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    cfg_reg_e            regs [5];
    logic [CfgDataW-1:0] data [5];
    regs = '{REG_BLEND_MODE, REG_BG_COLOR, REG_AA_ENABLE, REG_WIDTH, REG_HEIGHT};
    data = '{CfgDataW'(mode), CfgDataW'(bg), CfgDataW'(aa), CfgDataW'(w), CfgDataW'(h)};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (regs[i])
        REG_BLEND_MODE: cur_mode   = data[i][1:0];
        REG_BG_COLOR:   cur_bg     = data[i][ColorW-1:0];
        REG_AA_ENABLE:  cur_aa     = data[i][0];
        REG_WIDTH:      cur_width  = data[i][SizeW-1:0];
        REG_HEIGHT:     cur_height = data[i][SizeW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset register values: frame corners, just-outside pixels and the alpha
  // extremes in the over mode.
  task automatic test_default_registers();
    send_pixel(make_pixel(0, 0, 255, 255, 255, 255, 0, 0, 0));
    send_pixel(make_pixel(639, 479, 0, 0, 0, 0, 255, 255, 255));
    send_pixel(make_pixel(640, 0, 10, 20, 30, 40, 50, 60, 70));
    send_pixel(make_pixel(0, 480, 10, 20, 30, 40, 50, 60, 70));
    send_pixel(make_pixel(65535, 65535, 255, 255, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(100, 200, 200, 100, 50, 128, 30, 60, 90));
  endtask

  // Each blend mode, the reserved code and the pass-through path.
  task automatic test_blend_modes();
    // Background delta with a mix of positive and negative deltas.
    configure(BLEND_DELTA, 24'h00FF00, 1'b1, 12'd640, 12'd480);
    send_pixel(make_pixel(1, 1, 255, 0, 255, 255, 255, 0, 128));
    send_pixel(make_pixel(2, 3, 0, 0, 0, 1, 10, 10, 10));
    send_pixel(make_pixel(639, 0, 0, 0, 0, 255, 255, 255, 255));
    // Additive saturation.
    configure(BLEND_ADD, 24'hFFFFFF, 1'b1, 12'd640, 12'd480);
    send_pixel(make_pixel(5, 5, 255, 255, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(6, 5, 255, 128, 0, 0, 0, 128, 255));
    // Reserved code keeps the old color and stores nothing.
    configure(BlendReserved, 24'h123456, 1'b1, 12'd640, 12'd480);
    send_pixel(make_pixel(7, 8, 1, 2, 3, 255, 200, 150, 100));
    // Antialiasing off passes the source color through.
    configure(BLEND_OVER, 24'h000000, 1'b0, 12'd640, 12'd480);
    send_pixel(make_pixel(639, 479, 11, 22, 33, 128, 44, 55, 66));
  endtask

  // Oversized registers clamp to the limit; zero sizes reject everything.
  task automatic test_frame_limits();
    configure(BLEND_OVER, 24'h000000, 1'b1, 12'd4095, 12'd4095);
    send_pixel(make_pixel(2047, 2047, 255, 0, 128, 200, 0, 255, 128));
    send_pixel(make_pixel(2048, 0, 1, 1, 1, 1, 1, 1, 1));
    send_pixel(make_pixel(0, 2048, 1, 1, 1, 1, 1, 1, 1));
    configure(BLEND_OVER, 24'h000000, 1'b1, 12'd0, 12'd480);
    send_pixel(make_pixel(0, 0, 9, 9, 9, 9, 9, 9, 9));
    configure(BLEND_OVER, 24'h000000, 1'b1, 12'd640, 12'd0);
    send_pixel(make_pixel(0, 0, 9, 9, 9, 9, 9, 9, 9));
    configure(BLEND_ADD, 24'h000000, 1'b1, 12'd1, 12'd1);
    send_pixel(make_pixel(0, 0, 100, 100, 100, 100, 100, 100, 100));
    send_pixel(make_pixel(1, 0, 100, 100, 100, 100, 100, 100, 100));
  endtask

  // One register setting with random pixels until enough results are due.
  task automatic run_random_phase(logic [1:0] mode, logic [ColorW-1:0] bg, logic aa,
                                  logic [SizeW-1:0] w, logic [SizeW-1:0] h,
                                  int idle, int count);
    int first;
    configure(mode, bg, aa, w, h);
    idle_pct = idle;
    first = expected_count;
    while (expected_count - first < count) send_pixel(random_pixel());
    idle_pct = 0;
  endtask

  task automatic test_random_phases();
    run_random_phase(BLEND_OVER,    24'h000000,     1'b1, 12'd640,  12'd480,  0,  70);
    run_random_phase(BLEND_DELTA,   24'hC04080,     1'b1, 12'd64,   12'd32,   46, 70);
    run_random_phase(BLEND_ADD,     24'hFFFFFF,     1'b1, 12'd4095, 12'd4095, 16, 60);
    run_random_phase(BLEND_DELTA,   24'hFFFFFF,     1'b1, 12'd1,    12'd1,    0,  45);
    run_random_phase(BLEND_OVER,    ColorW'($urandom()), 1'b0, 12'd2048, 12'd2048, 46, 55);
    run_random_phase(BlendReserved, 24'h000000,     1'b1, 12'd300,  12'd200,  16, 45);
    run_random_phase(BLEND_DELTA,   24'h000000,     1'b1, 12'd2048, 12'd1,    46, 60);
    run_random_phase(BLEND_OVER,    24'h000000,     1'b1, 12'd1,    12'd2048, 0,  55);
    run_random_phase(BLEND_DELTA,   ColorW'($urandom()), 1'b1, 12'd17, 12'd9, 16, 70);
  endtask

  // Results are stable through their strobe cycle, so they are sampled at
  // the falling edge, away from the edge that updates them.
  always @(negedge clk_i) begin : check_results
    pixel_res_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_pixels.size() == 0) begin
        if (mismatch_count < MaxReport) begin
          $display("unexpected result: index %0d rgb %02h %02h %02h store %0b",
                   pixel_index_o, out_red_o, out_green_o, out_blue_o, store_pixel_o);
        end
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_index_o !== want.index || out_red_o !== want.red ||
            out_green_o !== want.green || out_blue_o !== want.blue ||
            store_pixel_o !== want.store) begin
          if (mismatch_count < MaxReport) begin
            $display("mismatch: expected index %0d rgb %02h %02h %02h store %0b",
                     want.index, want.red, want.green, want.blue, want.store);
            $display("          got      index %0d rgb %02h %02h %02h store %0b",
                     pixel_index_o, out_red_o, out_green_o, out_blue_o, store_pixel_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_BLEND_MODE;
    cfg_data_i  <= '0;
    {pixel_x_i, pixel_y_i, src_red_i, src_green_i, src_blue_i, src_alpha_i,
     old_red_i, old_green_i, old_blue_i} <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_registers();
    test_blend_modes();
    test_frame_limits();
    test_random_phases();

    wait_idle();
    if (pending_pixels.size() != 0) begin
      $display("%0d expected results never arrived", pending_pixels.size());
      mismatch_count += pending_pixels.size();
    end
    if (mismatch_count == 0) begin
      $display("pixel_alpha_blender_unit regression: pass");
    end else begin
      $display("pixel_alpha_blender_unit regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("pixel_alpha_blender_unit regression: fail");
    $finish;
  end

endmodule
